@@ design/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned PtrW      = $clog2(FifoDepth);
	localparam int unsigned CntW      = $clog2(FifoDepth + 1);

	localparam logic [7:0] CharPad   = 8'd61;
	localparam logic [7:0] CharSpace = 8'd32;
	localparam logic [7:0] CharPlus  = 8'd43;
	localparam logic [7:0] CharSlash = 8'd47;
	localparam logic [5:0] SxtPlus   = 6'd62;
	localparam logic [5:0] SxtSlash  = 6'd63;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SYM,
		KIND_PAD,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] sextet;
		logic       eot;
	} req_t;

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CharSpace) || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic req_t classify(input logic       present,
	                                  input logic [7:0] c,
	                                  input logic       eot);
		req_t r;
		logic [7:0] d;
		r.kind   = KIND_NONE;
		r.sextet = '0;
		r.eot    = eot;
		d        = '0;
		if (present && !is_blank(c)) begin
			if (c inside {[8'd65:8'd90]}) begin
				d        = c - 8'd65;
				r.kind   = KIND_SYM;
				r.sextet = d[5:0];
			end else if (c inside {[8'd97:8'd122]}) begin
				d        = c - 8'd71;
				r.kind   = KIND_SYM;
				r.sextet = d[5:0];
			end else if (c inside {[8'd48:8'd57]}) begin
				d        = c + 8'd4;
				r.kind   = KIND_SYM;
				r.sextet = d[5:0];
			end else if (c == CharPlus) begin
				r.kind   = KIND_SYM;
				r.sextet = SxtPlus;
			end else if (c == CharSlash) begin
				r.kind   = KIND_SYM;
				r.sextet = SxtSlash;
			end else if (c == CharPad) begin
				r.kind   = KIND_PAD;
			end else begin
				r.kind   = KIND_BAD;
			end
		end
		classify = r;
	endfunction

endpackage

@@ design/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and pushes requests into the queue.
// Blank characters and empty items without an end marker are dropped here.
// ----------------------------------------------------------------------------
module b64d_front
	import b64d_pkg::*;
(
	input  logic       char_valid,
	output logic       char_stall,
	input  logic       char_present,
	input  logic [7:0] in_char,
	input  logic       end_of_text,
	input  logic       q_full,
	output logic       q_push,
	output req_t       q_data
);

	req_t req;

	always_comb begin
		req        = classify(char_present, in_char, end_of_text);
		char_stall = q_full;
		q_data     = req;
		q_push     = char_valid && !q_full && (req.kind != KIND_NONE || req.eot);
	end

endmodule

@@ design/b64d_fifo.sv @@
// ----------------------------------------------------------------------------
// b64d_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_fifo
	import b64d_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_data,
	output logic full,
	input  logic pop,
	output req_t pop_data,
	output logic empty
);

	req_t            mem_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntW'(FifoDepth));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Decoder state and result register. Pops one request per cycle while the
// result register is free and no status is held over; a byte plus status request holds the status over.
// ----------------------------------------------------------------------------
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  req_t       q_data,
	output logic       q_pop,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       is_status,
	output logic [7:0] out_byte,
	output logic       text_valid,
	output logic       last_result
);

	logic [1:0] phase_q;
	logic [7:0] partial_q;
	logic [1:0] pad_cnt_q;
	logic       pad_seen_q;
	logic       err_q;
	logic       stat_pend_q;
	logic       stat_ok_q;
	logic       res_valid_q;
	logic       is_status_q;
	logic [7:0] out_byte_q;
	logic       text_valid_q;

	logic [1:0] phase_d;
	logic [7:0] partial_d;
	logic [1:0] pad_cnt_d;
	logic       pad_seen_d;
	logic       err_d;
	logic       byte_en;
	logic [7:0] byte_val;
	logic       ok;
	logic       res_free;
	logic [1:0] sum;

	assign res_free    = !res_valid_q || !res_stall;
	assign q_pop       = res_free && !stat_pend_q && !q_empty;
	assign res_valid   = res_valid_q;
	assign is_status   = is_status_q;
	assign out_byte    = out_byte_q;
	assign text_valid  = text_valid_q;
	assign last_result = is_status_q;

	always_comb begin
		phase_d    = phase_q;
		partial_d  = partial_q;
		pad_cnt_d  = pad_cnt_q;
		pad_seen_d = pad_seen_q;
		err_d      = err_q;
		byte_en    = 1'b0;
		byte_val   = '0;
		if (!err_q) begin
			case (q_data.kind)
				KIND_PAD: begin
					pad_seen_d = 1'b1;
					if (pad_cnt_q == 2'd2) begin
						err_d = 1'b1;
					end else begin
						pad_cnt_d = pad_cnt_q + 2'd1;
					end
				end
				KIND_BAD: begin
					err_d = 1'b1;
				end
				KIND_SYM: begin
					if (pad_seen_q) begin
						err_d = 1'b1;
					end else begin
						phase_d = phase_q + 2'd1;
						case (phase_q)
							2'd0: begin
								partial_d = {q_data.sextet, 2'b00};
							end
							2'd1: begin
								byte_en   = 1'b1;
								byte_val  = partial_q | {6'b0, q_data.sextet[5:4]};
								partial_d = {q_data.sextet[3:0], 4'b0};
							end
							2'd2: begin
								byte_en   = 1'b1;
								byte_val  = partial_q | {4'b0, q_data.sextet[5:2]};
								partial_d = {q_data.sextet[1:0], 6'b0};
							end
							default: begin
								byte_en   = 1'b1;
								byte_val  = partial_q | {2'b0, q_data.sextet};
								partial_d = '0;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
		sum = phase_d + pad_cnt_d;
		ok  = !err_d && (sum == 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			partial_q   <= '0;
			pad_cnt_q   <= '0;
			pad_seen_q  <= 1'b0;
			err_q       <= 1'b0;
			stat_pend_q <= 1'b0;
			stat_ok_q   <= 1'b0;
			res_valid_q <= 1'b0;
			is_status_q <= 1'b0;
		end else if (res_free) begin
			if (stat_pend_q) begin
				stat_pend_q <= 1'b0;
				res_valid_q <= 1'b1;
				is_status_q <= 1'b1;
			end else if (!q_empty) begin
				if (q_data.eot) begin
					phase_q    <= '0;
					partial_q  <= '0;
					pad_cnt_q  <= '0;
					pad_seen_q <= 1'b0;
					err_q      <= 1'b0;
				end else begin
					phase_q    <= phase_d;
					partial_q  <= partial_d;
					pad_cnt_q  <= pad_cnt_d;
					pad_seen_q <= pad_seen_d;
					err_q      <= err_d;
				end
				stat_ok_q   <= ok;
				stat_pend_q <= byte_en && q_data.eot;
				res_valid_q <= byte_en || q_data.eot;
				is_status_q <= !byte_en && q_data.eot;
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_free) begin
			if (stat_pend_q) begin
				out_byte_q   <= '0;
				text_valid_q <= stat_ok_q;
			end else if (!q_empty) begin
				out_byte_q   <= byte_en ? byte_val : 8'd0;
				text_valid_q <= !byte_en && ok;
			end
		end
	end

endmodule

@@ design/base64_stream_decoder_top.sv @@
// An accepted request passes through the request queue and then the result register on its
// way to the outputs. Throughput: one character per cycle while the queue is not full; a
// character with an end marker that also completes a byte yields a byte, then a status result.
// A four-entry request queue separates character intake from result delivery.
// Reset (arst_n low, asynchronous) empties the queue, clears decoder state and
// drops any pending result.
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder with a final validity status per text.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic       char_present,
	input  logic [7:0] in_char,
	input  logic       end_of_text,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       is_status,
	output logic [7:0] out_byte,
	output logic       text_valid,
	output logic       last_result
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	req_t q_wdata;
	req_t q_rdata;

	b64d_front u_front (
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_present (char_present),
		.in_char      (in_char),
		.end_of_text  (end_of_text),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	b64d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.is_status   (is_status),
		.out_byte    (out_byte),
		.text_valid  (text_valid),
		.last_result (last_result)
	);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 stream decoder. A short directed text set
// is followed by random texts, mostly well formed with random whitespace and
// random end markers, plus corrupted texts and random noise. A local decoder
// predicts every data byte and status; results are checked in order under
// several sender-idle and receiver-stall profiles.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [7:0] CH_PAD   = "=";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [5:0] SXT_PLUS  = 6'd62;
	localparam logic [5:0] SXT_SLASH = 6'd63;
	localparam int ITEMS_PER_PHASE = 300;

	typedef enum int {TXT_CLEAN, TXT_BROKEN, TXT_NOISE} text_kind_t;

	typedef struct packed {
		logic       present;
		logic [7:0] ch;
		logic       eot;
	} char_req_t;

	typedef struct packed {
		logic       st;
		logic [7:0] b;
		logic       ok;
		logic       last;
	} dec_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	logic       char_present = 1'b0;
	logic [7:0] in_char = 8'd0;
	logic       end_of_text = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       is_status;
	logic [7:0] out_byte;
	logic       text_valid;
	logic       last_result;

	base64_stream_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_present(char_present),
		.in_char     (in_char),
		.end_of_text (end_of_text),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.is_status   (is_status),
		.out_byte    (out_byte),
		.text_valid  (text_valid),
		.last_result (last_result)
	);

	always #5 clk = ~clk;

	char_req_t pend_q[$];
	dec_res_t  expected_out_q[$];
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        n_items = 0;
	int        n_errors = 0;
	int        n_texts = 0;
	int        n_valid_texts = 0;
	int        n_bytes = 0;
	logic      req_taken = 1'b0;

	// decoder state mirror
	logic [1:0] dec_phase = '0;
	logic [7:0] dec_bits = '0;
	logic [1:0] dec_pads = '0;
	logic       dec_pad_seen = 1'b0;
	logic       dec_err = 1'b0;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic sextet_lookup(input logic [7:0] c, output logic [5:0] v);
		logic [7:0] d;
		d = 8'd0;
		v = 6'd0;
		if (c >= "A" && c <= "Z") begin
			d = c - "A";
		end else if (c >= "a" && c <= "z") begin
			d = c - "a" + 8'd26;
		end else if (c >= "0" && c <= "9") begin
			d = c - "0" + 8'd52;
		end else if (c == CH_PLUS) begin
			d = {2'b00, SXT_PLUS};
		end else if (c == CH_SLASH) begin
			d = {2'b00, SXT_SLASH};
		end else begin
			return 1'b0;
		end
		v = d[5:0];
		return 1'b1;
	endfunction

	function automatic logic [7:0] sym_char(input logic [5:0] v);
		if (v < 6'd26)
			return "A" + v;
		if (v < 6'd52)
			return "a" + (v - 6'd26);
		if (v < 6'd62)
			return "0" + (v - 6'd52);
		return (v == SXT_PLUS) ? CH_PLUS : CH_SLASH;
	endfunction

	function automatic logic [7:0] rand_blank();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : CH_TAB + k[7:0];
	endfunction

	task automatic decode_step(input logic present, input logic [7:0] c, input logic eot);
		logic [5:0] v;
		logic       is_sym;
		logic [1:0] fill;
		if (present && !dec_err && !is_ws(c)) begin
			is_sym = sextet_lookup(c, v);
			if (c == CH_PAD) begin
				dec_pad_seen = 1'b1;
				if (dec_pads == 2'd2)
					dec_err = 1'b1;
				else
					dec_pads = dec_pads + 2'd1;
			end else if (!is_sym || dec_pad_seen) begin
				dec_err = 1'b1;
			end else begin
				case (dec_phase)
					2'd0: dec_bits = {v, 2'b00};
					2'd1: begin
						expected_out_q.push_back({1'b0, dec_bits | {6'b0, v[5:4]}, 1'b0, 1'b0});
						dec_bits = {v[3:0], 4'b0};
					end
					2'd2: begin
						expected_out_q.push_back({1'b0, dec_bits | {4'b0, v[5:2]}, 1'b0, 1'b0});
						dec_bits = {v[1:0], 6'b0};
					end
					default: begin
						expected_out_q.push_back({1'b0, dec_bits | {2'b0, v}, 1'b0, 1'b0});
						dec_bits = 8'd0;
					end
				endcase
				dec_phase = dec_phase + 2'd1;
			end
		end
		if (eot) begin
			fill = dec_phase + dec_pads;
			expected_out_q.push_back({1'b1, 8'd0, !dec_err && fill == 2'd0, 1'b1});
			dec_phase = '0;
			dec_bits = '0;
			dec_pads = '0;
			dec_pad_seen = 1'b0;
			dec_err = 1'b0;
		end
	endtask

	task automatic push_req(input logic present, input logic [7:0] c, input logic eot);
		pend_q.push_back({present, c, eot});
		if (present || eot)
			n_items++;
	endtask

	task automatic gen_text(input text_kind_t kind);
		logic [7:0] txt[$];
		logic [7:0] b[3];
		logic [5:0] s[4];
		int         nbytes;
		int         k;
		int         pos;
		int         r;
		logic       attach;
		if (kind == TXT_NOISE) begin
			repeat ($urandom_range(1, 8)) begin
				r = $urandom_range(99);
				if (r < 50)
					txt.push_back(sym_char(6'($urandom_range(63))));
				else if (r < 70)
					txt.push_back(CH_PAD);
				else if (r < 85)
					txt.push_back(rand_blank());
				else
					txt.push_back(8'($urandom_range(255)));
			end
		end else begin
			nbytes = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 9);
			for (int i = 0; i < nbytes; i += 3) begin
				k = (nbytes - i >= 3) ? 3 : nbytes - i;
				for (int j = 0; j < 3; j++)
					b[j] = (j < k) ? 8'($urandom_range(255)) : 8'd0;
				s[0] = b[0][7:2];
				s[1] = {b[0][1:0], b[1][7:4]};
				s[2] = {b[1][3:0], b[2][7:6]};
				s[3] = b[2][5:0];
				for (int j = 0; j <= k; j++)
					txt.push_back(sym_char(s[j]));
				for (int j = k; j < 3; j++)
					txt.push_back(CH_PAD);
			end
			if (kind == TXT_BROKEN) begin
				pos = (txt.size() > 0) ? $urandom_range(txt.size() - 1) : 0;
				case ($urandom_range(3))
					0: if (txt.size() > 0) txt[pos] = 8'($urandom_range(255));
					1: if (txt.size() > 0) txt[pos] = CH_PAD;
					2: if (txt.size() > 0) void'(txt.pop_back());
					default: txt.push_back(($urandom_range(1) == 0) ? CH_PAD :
					                       sym_char(6'($urandom_range(63))));
				endcase
			end
		end
		attach = (txt.size() > 0) && ($urandom_range(1) == 0);
		foreach (txt[i]) begin
			if ($urandom_range(9) == 0)
				push_req(1'b1, rand_blank(), 1'b0);
			if ($urandom_range(29) == 0)
				push_req(1'b0, 8'($urandom_range(255)), 1'b0);
			push_req(1'b1, txt[i], attach && (i == txt.size() - 1));
		end
		if (!attach) begin
			if ($urandom_range(3) == 0)
				push_req(1'b1, rand_blank(), 1'b1);
			else
				push_req(1'b0, 8'($urandom_range(255)), 1'b1);
		end
	endtask

	// driver: new request or stall at the falling edge
	always @(negedge clk) begin : drv
		char_req_t nxt;
		res_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && (!char_valid || req_taken)) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = pend_q.pop_front();
				char_valid   <= 1'b1;
				char_present <= nxt.present;
				in_char      <= nxt.ch;
				end_of_text  <= nxt.eot;
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// monitor: accepted requests feed the predictor, accepted results are checked
	always @(posedge clk) begin : mon
		dec_res_t got;
		dec_res_t want;
		req_taken <= arst_n && char_valid && !char_stall;
		if (arst_n) begin
			if (char_valid && !char_stall)
				decode_step(char_present, in_char, end_of_text);
			if (res_valid && !res_stall) begin
				got = {is_status, out_byte, text_valid, last_result};
				if (expected_out_q.size() == 0) begin
					$display("%0t: unexpected result st=%0d byte=%02h valid=%0d last=%0d",
					         $time, got.st, got.b, got.ok, got.last);
					n_errors++;
				end else begin
					want = expected_out_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected st=%0d byte=%02h valid=%0d last=%0d",
						         $time, want.st, want.b, want.ok, want.last,
						         ", got st=%0d byte=%02h valid=%0d last=%0d",
						         got.st, got.b, got.ok, got.last);
						n_errors++;
					end
					if (want.st) begin
						n_texts++;
						if (want.ok)
							n_valid_texts++;
					end else begin
						n_bytes++;
					end
				end
			end
		end
	end

	initial begin : stim
		int pct_idle[4];
		int pct_stall[4];
		int target;
		int r;
		pct_idle  = '{0, 53, 0, 6};
		pct_stall = '{0, 0, 53, 6};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 4; p++) begin
			idle_pct  = pct_idle[p];
			stall_pct = pct_stall[p];
			if (p == 0) begin
				// "TWFu" decodes to "Man"
				push_req(1'b1, "T", 1'b0);
				push_req(1'b1, "W", 1'b0);
				push_req(1'b1, "F", 1'b0);
				push_req(1'b1, "u", 1'b1);
				// empty text
				push_req(1'b0, 8'hFF, 1'b1);
				// plus, slash, all blanks, end marker on a byte-completing symbol
				push_req(1'b1, CH_PLUS, 1'b0);
				push_req(1'b1, CH_TAB, 1'b0);
				push_req(1'b1, CH_SLASH, 1'b0);
				push_req(1'b1, 8'd10, 1'b0);
				push_req(1'b1, 8'd11, 1'b0);
				push_req(1'b1, 8'd12, 1'b0);
				push_req(1'b1, CH_CR, 1'b0);
				push_req(1'b1, CH_SPACE, 1'b0);
				push_req(1'b1, "9", 1'b0);
				push_req(1'b1, "z", 1'b1);
				// no character and no end marker
				push_req(1'b0, 8'hFF, 1'b0);
				// third pad
				push_req(1'b1, "T", 1'b0);
				push_req(1'b1, "Q", 1'b0);
				push_req(1'b1, CH_PAD, 1'b0);
				push_req(1'b1, CH_PAD, 1'b0);
				push_req(1'b1, CH_PAD, 1'b1);
				// bad character
				push_req(1'b1, "a", 1'b0);
				push_req(1'b1, 8'h00, 1'b1);
				// symbol after pad
				push_req(1'b1, "a", 1'b0);
				push_req(1'b1, CH_PAD, 1'b0);
				push_req(1'b1, "b", 1'b1);
			end
			target = n_items + ITEMS_PER_PHASE;
			while (n_items < target) begin
				r = $urandom_range(99);
				gen_text(r < 70 ? TXT_CLEAN : (r < 88 ? TXT_BROKEN : TXT_NOISE));
			end
			while (pend_q.size() != 0 || char_valid || expected_out_q.size() != 0)
				@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (expected_out_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_out_q.size());
			n_errors++;
		end
		$display("Checked %0d texts (%0d valid) and %0d data bytes from %0d requests,",
		         n_texts, n_valid_texts, n_bytes, n_items);
		$display("over four sender-idle / receiver-stall profiles; %0d errors.", n_errors);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64_stream_decoder_top.sv
bench/tb_top.sv
